/* rtl/core/grwc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_pkg
// Shared types and constants of the grid ray wall cast block.
// ----------------------------------------------------------------------------
package grwc_pkg;

	localparam int MAP_COLS_MAX = 64;
	localparam int MAP_ROWS_MAX = 64;
	localparam int MAP_DEPTH    = MAP_COLS_MAX * MAP_ROWS_MAX;
	localparam int MAP_AW       = $clog2(MAP_DEPTH);

	localparam int DIR_EPS_Q30  = 1073;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 31;

	// divider: 72-bit dividend, 36-bit divisor, two quotient bits per cycle
	localparam int DIV_NW    = 72;
	localparam int DIV_DW    = 36;
	localparam int DIV_STEPS = DIV_NW / 2;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// square root: 72-bit radicand, 36-bit root, one root bit per cycle
	localparam int SQRT_RW    = 72;
	localparam int SQRT_QW    = SQRT_RW / 2;
	localparam int SQRT_CW    = $clog2(SQRT_QW);

	typedef enum logic [CFG_IW-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_TILE_SIZE   = 2'd2
	} grwc_cfg_idx_t;

	typedef struct packed {
		logic               mode;
		logic [5:0]         cell_col;
		logic [5:0]         cell_row;
		logic               cell_wall;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} grwc_in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} grwc_out_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_SQRT_WAIT,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DECIDE,
		ST_RD,
		ST_RD_WAIT,
		ST_TA,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_FIN,
		ST_OUT
	} grwc_state_t;

	typedef enum logic [2:0] {
		OP_U,
		OP_CX,
		OP_CZ,
		OP_TX,
		OP_TZ
	} grwc_op_t;

endpackage

/* rtl/core/grwc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grwc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/grwc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module grwc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [grwc_pkg::DIV_NW-1:0] num,
	input  logic [grwc_pkg::DIV_DW-1:0] den,
	output logic                        done,
	output logic [grwc_pkg::DIV_NW-1:0] quo
);
	import grwc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] work_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;

	logic [DIV_DW:0]   r1, r2;
	logic              ge1, ge2;
	logic [DIV_DW-1:0] r1n, r2n;
	logic [DIV_NW-1:0] w1, w2;

	always_comb begin
		r1  = {rem_q, work_q[DIV_NW-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1n = ge1 ? DIV_DW'(r1 - {1'b0, den_q}) : r1[DIV_DW-1:0];
		w1  = {work_q[DIV_NW-2:0], ge1};
		r2  = {r1n, w1[DIV_NW-1]};
		ge2 = r2 >= {1'b0, den_q};
		r2n = ge2 ? DIV_DW'(r2 - {1'b0, den_q}) : r2[DIV_DW-1:0];
		w2  = {w1[DIV_NW-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= w2;
			rem_q  <= r2n;
		end
	end

	assign done = done_q;
	assign quo  = work_q;

endmodule

/* rtl/core/grwc_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_sqrt
// Integer square root, floor, one root bit per cycle.
// ----------------------------------------------------------------------------
module grwc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grwc_pkg::SQRT_RW-1:0] rad,
	output logic                         done,
	output logic [grwc_pkg::SQRT_QW-1:0] root
);
	import grwc_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [SQRT_CW-1:0] cnt_q;
	logic [SQRT_RW-1:0] rad_q;
	logic [SQRT_QW+1:0] rem_q;
	logic [SQRT_QW-1:0] root_q;

	logic [SQRT_QW+3:0] rs, trial, rn;
	logic               ge;

	always_comb begin
		rs    = {rem_q, rad_q[SQRT_RW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = rs >= trial;
		rn    = ge ? rs - trial : rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CW'(SQRT_QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQRT_RW-3:0], 2'b00};
			rem_q  <= rn[SQRT_QW+1:0];
			root_q <= {root_q[SQRT_QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/core/grid_ray_wall_cast_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_wall_cast_top
// Wall map in a 1-bit RAM plus a grid walk of a ray in the x-z plane.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_stall/in_data): mode 0 writes one map cell in the
//    accept cycle and gives no result; mode 1 casts a ray and gives one result.
//  - out channel (out_valid/out_stall/out_data): one transaction per cast,
//    held in an output register while out_stall is high.
//  - cfg port: cfg_wr_en with cfg_index 0 grid width, 1 grid height,
//    2 tile size; write only while the block is idle.
//  - After reset the map RAM is swept to open, one cell a cycle, with
//    in_stall high. Config writes are taken during the sweep.
//  - One cast at a time. Its time is set by the shared 2-bit-per-cycle
//    divider and the square root: a ray that walks is set up first, then
//    each cell stepped takes one division and one map read, and last the
//    result is formed. A ray shorter than a quarter tile skips the
//    divisions and the walk.
//  - A result that waits on out_stall does not block the next transaction
//    on the in channel; the next cast waits only at its own result.
// ----------------------------------------------------------------------------
module grid_ray_wall_cast_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [grwc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [grwc_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  grwc_pkg::grwc_in_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output grwc_pkg::grwc_out_t         out_data
);
	import grwc_pkg::*;

	// configuration
	logic [6:0]  grid_width_q, grid_height_q;
	logic [30:0] tile_size_q;
	logic [6:0]  w_eff, h_eff;
	logic [30:0] tile_eff;

	// control
	grwc_state_t state_q, state_d;
	grwc_op_t    op_q, op_d;
	logic [MAP_AW-1:0] clr_q;
	logic        out_valid_q;
	grwc_out_t   out_data_q;

	// datapath
	logic signed [31:0] s_q [3];
	logic signed [31:0] e_q [3];
	logic signed [32:0] d_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] res_q [3];
	logic [66:0]        sum_q;
	logic [1:0]         ax_q;
	logic [35:0]        dist_q;
	logic               neg_q;
	logic signed [7:0]  cx_q, cz_q;
	logic signed [63:0] tx_q, tz_q, t_q;
	logic               hit_q, init_q, step_x_q;
	logic [35:0]        ta_q;
	logic [48:0]        prod_q;
	logic [67:0]        acc_q;

	// strobes
	logic accept, clearing, div_start, sqrt_start, load_out;

	// units
	logic [DIV_NW-1:0]  div_num, div_quo;
	logic [DIV_DW-1:0]  div_den;
	logic               div_neg, div_done;
	logic [SQRT_QW-1:0] sqrt_root;
	logic               sqrt_done;
	logic               ram_we, ram_wdata, ram_rdata;
	logic [MAP_AW-1:0]  ram_waddr, ram_raddr;

	// helpers
	logic [32:0]        d_mag;
	logic [65:0]        sq;
	logic [31:0]        u_abs0, u_abs2, u_abs_a;
	logic               ax_on, az_on;
	logic [37:0]        w_tile, h_tile;
	logic signed [40:0] nx, nz;
	logic signed [10:0] bx, bz;
	logic signed [42:0] bt, nb;
	logic [42:0]        nb_mag;
	logic               step_x;
	logic signed [63:0] tn;
	logic               tn_ge;
	logic               out_grid;
	logic signed [63:0] ta_s, two_tile;
	logic [35:0]        qv;
	logic signed [37:0] off, pos;
	logic signed [31:0] pos_sat;

	assign accept = in_valid && !in_stall;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 7'd64;
			grid_height_q <= 7'd64;
			tile_size_q   <= 31'd65536;
		end else if (cfg_wr_en) begin
			case (grwc_cfg_idx_t'(cfg_index))
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[6:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data[6:0];
				CFG_TILE_SIZE:   tile_size_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_width_q == '0) w_eff = 7'd1;
		else if (32'(grid_width_q) > MAP_COLS_MAX) w_eff = 7'(MAP_COLS_MAX);
		else w_eff = grid_width_q;
		if (grid_height_q == '0) h_eff = 7'd1;
		else if (32'(grid_height_q) > MAP_ROWS_MAX) h_eff = 7'(MAP_ROWS_MAX);
		else h_eff = grid_height_q;
		tile_eff = (tile_size_q == '0) ? 31'd1 : tile_size_q;
	end

	// ---------------- arithmetic helpers ----------------
	always_comb begin
		d_mag   = d_q[ax_q][32] ? 33'(-d_q[ax_q]) : 33'(d_q[ax_q]);
		sq      = 66'(d_mag) * 66'(d_mag);
		u_abs0  = u_q[0][31] ? 32'(-u_q[0]) : 32'(u_q[0]);
		u_abs2  = u_q[2][31] ? 32'(-u_q[2]) : 32'(u_q[2]);
		u_abs_a = u_q[ax_q][31] ? 32'(-u_q[ax_q]) : 32'(u_q[ax_q]);
		ax_on   = u_abs0 > 32'(DIR_EPS_Q30);
		az_on   = u_abs2 > 32'(DIR_EPS_Q30);

		w_tile = 38'(w_eff) * 38'(tile_eff);
		h_tile = 38'(h_eff) * 38'(tile_eff);
		nx = $signed({{8{s_q[0][31]}}, s_q[0], 1'b0}) - $signed({10'b0, tile_eff})
			+ $signed({3'b0, w_tile});
		nz = $signed({{8{s_q[2][31]}}, s_q[2], 1'b0}) - $signed({9'b0, tile_eff, 1'b0})
			+ $signed({3'b0, h_tile});

		// next cell boundary in Q16.18, relative to the grid center
		bx = $signed({cx_q[7], cx_q, 2'b00}) + (u_q[0][31] ? 11'sd2 : 11'sd6)
			- $signed({3'b0, w_eff, 1'b0});
		bz = $signed({cz_q[7], cz_q, 2'b00}) + (u_q[2][31] ? 11'sd4 : 11'sd8)
			- $signed({3'b0, h_eff, 1'b0});
		if (op_q == OP_TZ) begin
			bt = 43'(bz * $signed({1'b0, tile_eff}));
			nb = bt - $signed({{9{s_q[2][31]}}, s_q[2], 2'b00});
		end else begin
			bt = 43'(bx * $signed({1'b0, tile_eff}));
			nb = bt - $signed({{9{s_q[0][31]}}, s_q[0], 2'b00});
		end
		nb_mag = nb[42] ? 43'(-nb) : 43'(nb);

		step_x   = ax_on && (!az_on || (tx_q < tz_q));
		tn       = step_x ? tx_q : tz_q;
		tn_ge    = tn >= $signed({28'b0, dist_q});
		out_grid = cx_q[7] || (cx_q >= $signed({1'b0, w_eff}))
			|| cz_q[7] || (cz_q >= $signed({1'b0, h_eff}));

		ta_s     = t_q - $signed({33'b0, tile_eff});
		two_tile = $signed({32'b0, tile_eff, 1'b0});

		qv      = acc_q[67:32];
		off     = u_q[ax_q][31] ? -$signed({2'b0, qv}) : $signed({2'b0, qv});
		pos     = $signed({{6{s_q[ax_q][31]}}, s_q[ax_q]}) + off;
		if (pos > 38'sd2147483647) pos_sat = 32'sh7FFFFFFF;
		else if (pos < -38'sd2147483648) pos_sat = 32'sh80000000;
		else pos_sat = pos[31:0];
	end

	// divider operands
	always_comb begin
		div_num = '0;
		div_den = '0;
		div_neg = 1'b0;
		case (op_q)
			OP_U: begin
				div_num = {7'b0, d_mag, 32'b0};
				div_den = dist_q;
				div_neg = d_q[ax_q][32];
			end
			OP_CX: begin
				div_num = nx[40] ? '0 : DIV_NW'(nx);
				div_den = {4'b0, tile_eff, 1'b0};
			end
			OP_CZ: begin
				div_num = nz[40] ? '0 : DIV_NW'(nz);
				div_den = {4'b0, tile_eff, 1'b0};
			end
			OP_TX: begin
				div_num = {nb_mag[41:0], 30'b0};
				div_den = {4'b0, u_abs0};
				div_neg = nb[42] ^ u_q[0][31];
			end
			OP_TZ: begin
				div_num = {nb_mag[41:0], 30'b0};
				div_den = {4'b0, u_abs2};
				div_neg = nb[42] ^ u_q[2][31];
			end
			default: ;
		endcase
	end

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			ST_CLEAR: if (clr_q == MAP_AW'(MAP_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept && in_data.mode) state_d = ST_SQ;
			ST_SQ: if (ax_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT: state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (sqrt_done) state_d = ST_CHECK;
			ST_CHECK: begin
				if (dist_q >= 36'(tile_eff)) begin
					state_d = ST_DIV_GO;
					op_d    = OP_U;
				end else begin
					state_d = ST_TA;
				end
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_DIV_GO;
					case (op_q)
						OP_U: if (ax_q == 2'd2) op_d = OP_CX;
						OP_CX: op_d = OP_CZ;
						OP_CZ: begin
							if (ax_on) op_d = OP_TX;
							else if (az_on) op_d = OP_TZ;
							else state_d = ST_DECIDE;
						end
						OP_TX: begin
							if (init_q && az_on) op_d = OP_TZ;
							else state_d = ST_DECIDE;
						end
						default: state_d = ST_DECIDE;
					endcase
				end
			end
			ST_DECIDE: begin
				if ((!ax_on && !az_on) || tn_ge) state_d = ST_TA;
				else state_d = ST_RD;
			end
			ST_RD: state_d = out_grid ? ST_TA : ST_RD_WAIT;
			ST_RD_WAIT: begin
				if (ram_rdata) begin
					state_d = ST_TA;
				end else begin
					state_d = ST_DIV_GO;
					op_d    = step_x_q ? OP_TX : OP_TZ;
				end
			end
			ST_TA: state_d = hit_q ? ST_MUL_LO : ST_OUT;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_MUL_FIN;
			ST_MUL_FIN: state_d = (ax_q == 2'd2) ? ST_OUT : ST_MUL_LO;
			ST_OUT: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		clearing   = (state_q == ST_CLEAR);
		div_start  = (state_q == ST_DIV_GO);
		sqrt_start = (state_q == ST_SQRT);
		load_out   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= OP_U;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && in_data.mode) begin
					s_q[0] <= in_data.start_x;
					s_q[1] <= in_data.start_y;
					s_q[2] <= in_data.start_z;
					e_q[0] <= in_data.end_x;
					e_q[1] <= in_data.end_y;
					e_q[2] <= in_data.end_z;
					d_q[0] <= 33'(in_data.end_x) - 33'(in_data.start_x);
					d_q[1] <= 33'(in_data.end_y) - 33'(in_data.start_y);
					d_q[2] <= 33'(in_data.end_z) - 33'(in_data.start_z);
					sum_q  <= '0;
					ax_q   <= '0;
				end
			end
			ST_SQ: begin
				sum_q <= sum_q + 67'(sq);
				ax_q  <= ax_q + 1'b1;
			end
			ST_SQRT_WAIT: if (sqrt_done) dist_q <= sqrt_root;
			ST_CHECK: begin
				ax_q   <= '0;
				hit_q  <= 1'b0;
				init_q <= 1'b1;
			end
			ST_DIV_GO: neg_q <= div_neg;
			ST_DIV_WAIT: begin
				if (div_done) begin
					case (op_q)
						OP_U: begin
							u_q[ax_q] <= neg_q ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
							ax_q      <= ax_q + 1'b1;
						end
						OP_CX: cx_q <= (div_quo >= DIV_NW'(w_eff)) ? $signed({1'b0, w_eff} - 8'd1)
							: $signed(div_quo[7:0]);
						OP_CZ: cz_q <= (div_quo >= DIV_NW'(h_eff)) ? $signed({1'b0, h_eff} - 8'd1)
							: $signed(div_quo[7:0]);
						OP_TX: tx_q <= neg_q ? -$signed({1'b0, div_quo[62:0]})
							: $signed({1'b0, div_quo[62:0]});
						OP_TZ: tz_q <= neg_q ? -$signed({1'b0, div_quo[62:0]})
							: $signed({1'b0, div_quo[62:0]});
						default: ;
					endcase
				end
			end
			ST_DECIDE: begin
				init_q   <= 1'b0;
				step_x_q <= step_x;
				if ((ax_on || az_on) && !tn_ge) begin
					t_q <= tn;
					// ties go to the row axis
					if (step_x) cx_q <= u_q[0][31] ? cx_q - 8'sd1 : cx_q + 8'sd1;
					else cz_q <= u_q[2][31] ? cz_q - 8'sd1 : cz_q + 8'sd1;
				end
			end
			ST_RD_WAIT: if (ram_rdata) hit_q <= 1'b1;
			ST_TA: begin
				ax_q <= '0;
				ta_q <= (ta_s < two_tile) ? two_tile[35:0] : ta_s[35:0];
				if (!hit_q) begin
					res_q[0] <= e_q[0];
					res_q[1] <= e_q[1];
					res_q[2] <= e_q[2];
				end
			end
			ST_MUL_LO: prod_q <= 49'(u_abs_a[30:0]) * 49'(ta_q[17:0]);
			ST_MUL_HI: acc_q <= 68'(prod_q)
				+ (68'(50'(u_abs_a[30:0]) * 50'(ta_q[35:18])) << 18);
			ST_MUL_FIN: begin
				res_q[ax_q] <= pos_sat;
				ax_q        <= ax_q + 1'b1;
			end
			ST_OUT: begin
				if (load_out) begin
					out_data_q.hit   <= hit_q;
					out_data_q.hit_x <= res_q[0];
					out_data_q.hit_y <= res_q[1];
					out_data_q.hit_z <= res_q[2];
				end
			end
			default: ;
		endcase
	end

	// ---------------- wall map ----------------
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		if (clearing) begin
			ram_we = 1'b1;
		end else if (accept && !in_data.mode && (32'(in_data.cell_col) < MAP_COLS_MAX)
			&& (32'(in_data.cell_row) < MAP_ROWS_MAX)) begin
			ram_we    = 1'b1;
			ram_waddr = MAP_AW'(in_data.cell_row) * MAP_AW'(MAP_COLS_MAX)
				+ MAP_AW'(in_data.cell_col);
			ram_wdata = in_data.cell_wall;
		end
		ram_raddr = MAP_AW'(cz_q[6:0]) * MAP_AW'(MAP_COLS_MAX) + MAP_AW'(cx_q[6:0]);
	end

	grwc_ram #(
		.WIDTH (1),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	grwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	grwc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    ({1'b0, sum_q, 4'b0000}),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
